// ===== sv/sma_crossover_signal_macros.svh =====
// Assertion shorthands used by the checker file sma_chk.sv.
`ifndef SMA_CROSSOVER_SIGNAL_MACROS_SVH
`define SMA_CROSSOVER_SIGNAL_MACROS_SVH

// same-cycle implication, muted during reset
`define SMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sma check failed");

// next-cycle implication, muted during reset
`define SMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sma check failed");

`endif

// ===== sv/sma_pkg.sv =====
`default_nettype none

package sma_pkg;

  localparam int PRICE_W        = 32;
  localparam int BAL_W          = 48;
  localparam int WIN_W          = 9;
  localparam int FRAC_W         = 17;
  localparam int FRAC_SHIFT     = 16;
  localparam int MAX_WINDOW_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [WIN_W-1:0]  LONG_RST  = 9'd200;
  localparam logic [WIN_W-1:0]  SHORT_RST = 9'd50;
  localparam logic [FRAC_W-1:0] FRAC_RST  = 17'd6554;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;

  // shared shift-add / subtract unit
  localparam int OPW    = 48;
  localparam int ACC_W  = OPW + FRAC_W;
  localparam int STEP_W = $clog2(OPW + 1);

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_ABOVE = 2'd1,
    REL_BELOW = 2'd2
  } rel_t;

  typedef enum logic [1:0] {
    CFG_LONG  = 2'd0,
    CFG_SHORT = 2'd1,
    CFG_FRAC  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [STEP_W-1:0] steps;
  } alu_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_S,
    ST_RD_L,
    ST_UPD,
    ST_CHK,
    ST_LHS_GO,
    ST_LHS_WAIT,
    ST_RHS_GO,
    ST_RHS_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [PRICE_W-1:0] close_price;
    logic [BAL_W-1:0]   available_balance;
  } tick_t;

  typedef struct packed {
    action_t            action;
    logic [BAL_W-1:0]   trade_shares;
    logic [PRICE_W-1:0] trade_price;
    logic               position_held;
    logic               zero_price_skip;
  } trade_t;

endpackage

`default_nettype wire

// ===== sv/sma_ring.sv =====
`default_nettype none

module sma_ring #(
  parameter int DEPTH = sma_pkg::MAX_WINDOW_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [sma_pkg::PRICE_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [sma_pkg::PRICE_W-1:0]  rdata
);

  logic [sma_pkg::PRICE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sma_alu.sv =====
`default_nettype none

// One adder, one bit per cycle: MSB-first shift-add multiply or restoring divide.
// Multiplier / dividend enter MSB-aligned in b_in; the quotient collects in b.
module sma_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  sma_pkg::alu_cmd_t           cmd,
  input  logic [sma_pkg::OPW-1:0]     a_in,
  input  logic [sma_pkg::OPW-1:0]     b_in,
  output logic                        done,
  output logic [sma_pkg::ACC_W-1:0]   acc,
  output logic [sma_pkg::OPW-1:0]     quo
);

  localparam int AW = sma_pkg::ACC_W;
  localparam int OW = sma_pkg::OPW;

  sma_pkg::alu_op_t          op;
  logic                      busy;
  logic [sma_pkg::STEP_W-1:0] cnt;
  logic [OW-1:0]             a;
  logic [OW-1:0]             b;

  logic [AW-1:0] shifted;
  logic [AW-1:0] addend;
  logic [AW:0]   sum;
  logic          is_div;
  logic          carry;
  logic [AW-1:0] acc_next;
  logic [OW-1:0] b_next;

  always_comb begin
    is_div  = (op == sma_pkg::ALU_DIV);
    shifted = {acc[AW-2:0], is_div & b[OW-1]};
    if (is_div) begin
      addend = ~AW'(a);
    end else begin
      addend = b[OW-1] ? AW'(a) : '0;
    end
    // divide: shifted + ~a + 1, carry out means shifted >= a
    sum      = {1'b0, shifted} + {1'b0, addend} + (AW + 1)'(is_div);
    carry    = sum[AW];
    acc_next = (is_div && !carry) ? shifted : sum[AW-1:0];
    b_next   = {b[OW-2:0], is_div & carry};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
        op   <= cmd.op;
        a    <= a_in;
        b    <= b_in;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        b   <= b_next;
        cnt <= cnt - sma_pkg::STEP_W'(1);
        if (cnt == sma_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = b;

endmodule

`default_nettype wire

// ===== sv/sma_crossover_signal.sv =====
// Each tick transfer runs the short and long ring reads, the sum update and a check; once the long
// window is full, the short sum times the long window (zero while the short one is still filling)
// and the long sum times the short window are formed, and an upward cross that buys adds a 17-bit
// multiply and a 48-bit divide; the shared shift-add/subtract unit retires one bit per cycle.
// A new tick is taken only in idle, after the last trade result is loaded, which trade sink stalls hold up.
// rst (synchronous): history, position and registers go to defaults; ring contents undefined.
`default_nettype none

module sma_crossover_signal #(
  parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_valid,
  output logic                              tick_ready,
  input  sma_pkg::tick_t                    tick,
  output logic                              trade_valid,
  input  logic                              trade_ready,
  output sma_pkg::trade_t                   trade,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sma_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = sma_pkg::PRICE_W + PW;
  localparam int CW    = (CNT_W > sma_pkg::WIN_W) ? CNT_W : sma_pkg::WIN_W;
  localparam int OPW   = sma_pkg::OPW;
  localparam int ACC_W = sma_pkg::ACC_W;

  sma_pkg::state_t state, state_next;

  // configuration
  logic [sma_pkg::WIN_W-1:0]  long_win;
  logic [sma_pkg::WIN_W-1:0]  short_win;
  logic [sma_pkg::FRAC_W-1:0] frac;

  // history and position
  logic [PW-1:0]              wp;
  logic [CNT_W-1:0]           items_seen;
  logic [SUM_W-1:0]           short_sum;
  logic [SUM_W-1:0]           long_sum;
  sma_pkg::rel_t              last_rel;
  logic                       rel_valid;
  logic                       pos_open;
  logic [sma_pkg::BAL_W-1:0]  held;

  // per-tick working set
  logic [sma_pkg::PRICE_W-1:0] price;
  logic [sma_pkg::BAL_W-1:0]   bal;
  sma_pkg::action_t            act;
  logic [sma_pkg::BAL_W-1:0]   shares;
  logic [sma_pkg::PRICE_W-1:0] tprice;
  logic                        skip;
  logic [ACC_W-1:0]            lhs;

  logic [CW-1:0]               lw_ext;
  logic [CW-1:0]               sw_ext;
  logic [CNT_W-1:0]            lw_c;
  logic [CNT_W-1:0]            sw_c;
  logic [sma_pkg::FRAC_W-1:0]  frac_c;
  logic [CNT_W-1:0]            wp_ext;
  logic [PW-1:0]               idx_s;
  logic [PW-1:0]               idx_l;
  logic [SUM_W-1:0]            short_sum_upd;
  logic [SUM_W-1:0]            long_sum_upd;
  sma_pkg::rel_t               rel;
  logic                        buy_go;
  logic                        sell_go;
  logic                        trade_load;

  logic                        ring_we;
  logic [PW-1:0]               ring_raddr;
  logic [sma_pkg::PRICE_W-1:0] ring_rdata;

  sma_pkg::alu_cmd_t           alu_cmd;
  logic [OPW-1:0]              alu_a;
  logic [OPW-1:0]              alu_b;
  logic                        alu_done;
  logic [ACC_W-1:0]            alu_acc;
  logic [OPW-1:0]              alu_quo;

  sma_ring #(.DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (price),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  sma_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (alu_cmd),
    .a_in (alu_a),
    .b_in (alu_b),
    .done (alu_done),
    .acc  (alu_acc),
    .quo  (alu_quo)
  );

  // window clamp, ring offsets, sliding sums, cross detection
  always_comb begin
    lw_ext = CW'(long_win);
    sw_ext = CW'(short_win);
    if (lw_ext == '0) begin
      lw_c = CNT_W'(1);
    end else if (lw_ext > CW'(MAX_WINDOW)) begin
      lw_c = CNT_W'(MAX_WINDOW);
    end else begin
      lw_c = CNT_W'(lw_ext);
    end
    if (sw_ext == '0) begin
      sw_c = CNT_W'(1);
    end else if (sw_ext > CW'(MAX_WINDOW)) begin
      sw_c = CNT_W'(MAX_WINDOW);
    end else begin
      sw_c = CNT_W'(sw_ext);
    end
    frac_c = (frac > sma_pkg::FRAC_ONE) ? sma_pkg::FRAC_ONE : frac;

    // (wp - win) mod MAX_WINDOW; the true result is below MAX_WINDOW
    wp_ext = CNT_W'(wp);
    idx_s  = (wp_ext >= sw_c) ? PW'(wp_ext - sw_c)
                              : PW'(wp_ext + CNT_W'(MAX_WINDOW) - sw_c);
    idx_l  = (wp_ext >= lw_c) ? PW'(wp_ext - lw_c)
                              : PW'(wp_ext + CNT_W'(MAX_WINDOW) - lw_c);

    short_sum_upd = short_sum - ((items_seen >= sw_c) ? SUM_W'(ring_rdata) : '0)
                    + SUM_W'(price);
    long_sum_upd  = long_sum - ((items_seen >= lw_c) ? SUM_W'(ring_rdata) : '0)
                    + SUM_W'(price);

    if (lhs > alu_acc) begin
      rel = sma_pkg::REL_ABOVE;
    end else if (lhs < alu_acc) begin
      rel = sma_pkg::REL_BELOW;
    end else begin
      rel = sma_pkg::REL_EQUAL;
    end
    buy_go  = rel_valid && (last_rel != sma_pkg::REL_ABOVE) &&
              (rel == sma_pkg::REL_ABOVE) && !pos_open;
    sell_go = !buy_go && rel_valid && (last_rel != sma_pkg::REL_BELOW) &&
              (rel == sma_pkg::REL_BELOW) && pos_open && (held != '0);

    trade_load = (state == sma_pkg::ST_FIN) && (!trade_valid || trade_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sma_pkg::ST_IDLE: begin
        if (tick_valid) begin
          state_next = sma_pkg::ST_RD_S;
        end
      end
      sma_pkg::ST_RD_S: state_next = sma_pkg::ST_RD_L;
      sma_pkg::ST_RD_L: state_next = sma_pkg::ST_UPD;
      sma_pkg::ST_UPD:  state_next = sma_pkg::ST_CHK;
      sma_pkg::ST_CHK: begin
        if (items_seen < lw_c) begin
          state_next = sma_pkg::ST_FIN;
        end else if (items_seen >= sw_c) begin
          state_next = sma_pkg::ST_LHS_GO;
        end else begin
          state_next = sma_pkg::ST_RHS_GO;
        end
      end
      sma_pkg::ST_LHS_GO: state_next = sma_pkg::ST_LHS_WAIT;
      sma_pkg::ST_LHS_WAIT: begin
        if (alu_done) begin
          state_next = sma_pkg::ST_RHS_GO;
        end
      end
      sma_pkg::ST_RHS_GO: state_next = sma_pkg::ST_RHS_WAIT;
      sma_pkg::ST_RHS_WAIT: begin
        if (alu_done) begin
          state_next = (buy_go && price != '0) ? sma_pkg::ST_MUL_GO : sma_pkg::ST_FIN;
        end
      end
      sma_pkg::ST_MUL_GO: state_next = sma_pkg::ST_MUL_WAIT;
      sma_pkg::ST_MUL_WAIT: begin
        if (alu_done) begin
          state_next = sma_pkg::ST_DIV_GO;
        end
      end
      sma_pkg::ST_DIV_GO: state_next = sma_pkg::ST_DIV_WAIT;
      sma_pkg::ST_DIV_WAIT: begin
        if (alu_done) begin
          state_next = sma_pkg::ST_FIN;
        end
      end
      sma_pkg::ST_FIN: begin
        if (trade_load) begin
          state_next = sma_pkg::ST_IDLE;
        end
      end
      default: state_next = sma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    tick_ready    = 1'b0;
    ring_we       = 1'b0;
    ring_raddr    = idx_l;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = sma_pkg::ALU_MUL;
    alu_cmd.steps = sma_pkg::STEP_W'(CNT_W);
    alu_a         = '0;
    alu_b         = '0;
    unique case (state)
      sma_pkg::ST_IDLE: tick_ready = 1'b1;
      sma_pkg::ST_RD_S: ring_raddr = idx_s;
      sma_pkg::ST_UPD:  ring_we = 1'b1;
      sma_pkg::ST_LHS_GO: begin
        alu_cmd.start = 1'b1;
        alu_a         = OPW'(short_sum);
        alu_b         = {lw_c, {(OPW - CNT_W){1'b0}}};
      end
      sma_pkg::ST_RHS_GO: begin
        alu_cmd.start = 1'b1;
        alu_a         = OPW'(long_sum);
        alu_b         = {sw_c, {(OPW - CNT_W){1'b0}}};
      end
      sma_pkg::ST_MUL_GO: begin
        alu_cmd.start = 1'b1;
        alu_cmd.steps = sma_pkg::STEP_W'(sma_pkg::FRAC_W);
        alu_a         = bal;
        alu_b         = {frac_c, {(OPW - sma_pkg::FRAC_W){1'b0}}};
      end
      sma_pkg::ST_DIV_GO: begin
        // floor(bal*frac / (price<<16)) = floor((bal*frac >> 16) / price)
        alu_cmd.start = 1'b1;
        alu_cmd.op    = sma_pkg::ALU_DIV;
        alu_cmd.steps = sma_pkg::STEP_W'(OPW);
        alu_a         = OPW'(price);
        alu_b         = alu_acc[sma_pkg::FRAC_SHIFT +: OPW];
      end
      default: ;
    endcase
  end

  // window writes clear the history, so they land only between ticks
  assign cfg_ready = (state == sma_pkg::ST_IDLE) && !tick_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sma_pkg::ST_IDLE;
      long_win    <= sma_pkg::LONG_RST;
      short_win   <= sma_pkg::SHORT_RST;
      frac        <= sma_pkg::FRAC_RST;
      wp          <= '0;
      items_seen  <= '0;
      short_sum   <= '0;
      long_sum    <= '0;
      last_rel    <= sma_pkg::REL_EQUAL;
      rel_valid   <= 1'b0;
      pos_open    <= 1'b0;
      held        <= '0;
      trade_valid <= 1'b0;
    end else begin
      state <= state_next;

      unique case (state)
        sma_pkg::ST_IDLE: begin
          if (tick_valid) begin
            price  <= tick.close_price;
            bal    <= tick.available_balance;
            act    <= sma_pkg::ACT_NONE;
            shares <= '0;
            tprice <= '0;
            skip   <= 1'b0;
          end
        end
        sma_pkg::ST_RD_L: short_sum <= short_sum_upd;
        sma_pkg::ST_UPD: begin
          long_sum <= long_sum_upd;
          wp       <= (wp == PW'(MAX_WINDOW - 1)) ? '0 : wp + PW'(1);
          if (items_seen != CNT_W'(MAX_WINDOW)) begin
            items_seen <= items_seen + CNT_W'(1);
          end
        end
        sma_pkg::ST_CHK: lhs <= '0;
        sma_pkg::ST_LHS_WAIT: begin
          if (alu_done) begin
            lhs <= alu_acc;
          end
        end
        sma_pkg::ST_RHS_WAIT: begin
          if (alu_done) begin
            last_rel  <= rel;
            rel_valid <= 1'b1;
            if (buy_go && price == '0) begin
              skip <= 1'b1;
            end
            if (sell_go) begin
              act      <= sma_pkg::ACT_SELL;
              shares   <= held;
              tprice   <= price;
              held     <= '0;
              pos_open <= 1'b0;
            end
          end
        end
        sma_pkg::ST_DIV_WAIT: begin
          // zero shares: no trade, position stays closed
          if (alu_done && alu_quo != '0) begin
            act      <= sma_pkg::ACT_BUY;
            shares   <= alu_quo;
            tprice   <= price;
            held     <= alu_quo;
            pos_open <= 1'b1;
          end
        end
        default: ;
      endcase

      if (trade_load) begin
        trade_valid <= 1'b1;
        trade       <= '{action:          act,
                         trade_shares:    shares,
                         trade_price:     tprice,
                         position_held:   pos_open,
                         zero_price_skip: skip};
      end else if (trade_valid && trade_ready) begin
        trade_valid <= 1'b0;
      end

      // a window write drops the history; position is kept
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sma_pkg::CFG_LONG, sma_pkg::CFG_SHORT: begin
            if (cfg_index == sma_pkg::CFG_LONG) begin
              long_win <= cfg_data[sma_pkg::WIN_W-1:0];
            end else begin
              short_win <= cfg_data[sma_pkg::WIN_W-1:0];
            end
            items_seen <= '0;
            short_sum  <= '0;
            long_sum   <= '0;
            rel_valid  <= 1'b0;
            last_rel   <= sma_pkg::REL_EQUAL;
          end
          sma_pkg::CFG_FRAC: frac <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sma_chk.sv =====
`default_nettype none
`include "sma_crossover_signal_macros.svh"

module sma_chk (
  input logic            clk,
  input logic            rst,
  input logic            trade_valid,
  input logic            trade_ready,
  input sma_pkg::trade_t trade
);

  `SMA_ASSERT_NXT(a_trade_hold, trade_valid && !trade_ready, trade_valid && $stable(trade))
  `SMA_ASSERT_IMP(a_flat_quiet, trade_valid && trade.action == sma_pkg::ACT_NONE, trade.trade_shares == '0 && trade.trade_price == '0)
  `SMA_ASSERT_IMP(a_buy_opens, trade_valid && trade.action == sma_pkg::ACT_BUY, trade.position_held && trade.trade_shares != '0 && trade.trade_price != '0)
  `SMA_ASSERT_IMP(a_sell_closes, trade_valid && trade.action == sma_pkg::ACT_SELL, !trade.position_held && trade.trade_shares != '0)
  `SMA_ASSERT_IMP(a_skip_flat, trade_valid && trade.zero_price_skip, trade.action == sma_pkg::ACT_NONE && !trade.position_held)

endmodule

bind sma_crossover_signal sma_chk u_sma_chk (
  .clk         (clk),
  .rst         (rst),
  .trade_valid (trade_valid),
  .trade_ready (trade_ready),
  .trade       (trade)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sma_pkg::*;

  localparam int WIN_MAX = MAX_WINDOW_DEF;
  localparam int LIMIT = 1_500_000;
  localparam int TAIL = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [BAL_W-1:0] BAL_ALL = '1;

  typedef enum int {
    WALK_FLAT,
    WALK_TREND,
    WALK_HIGH,
    WALK_NOISE
  } price_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_ready;
  tick_t tick = '0;
  logic trade_valid;
  logic trade_ready = 1'b0;
  trade_t trade;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sma_crossover_signal DUT (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_ready(tick_ready),
    .tick(tick),
    .trade_valid(trade_valid),
    .trade_ready(trade_ready),
    .trade(trade),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // price history and signal state mirrored from the block
  logic [PRICE_W-1:0] px_hist [0:WIN_MAX-1];
  int unsigned hist_head, hist_fill;
  longint unsigned short_total, long_total;
  rel_t prior_rel;
  bit prior_rel_ok, holding;
  logic [BAL_W-1:0] held_qty;
  logic [WIN_W-1:0] long_len, short_len;
  logic [FRAC_W-1:0] buy_frac;

  tick_t tick_backlog[$];
  trade_t due_trades[$];
  tick_t next_tick;
  bit tick_took = 1'b0;
  bit jitter_on = 1'b0;
  bit wait_drain = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  logic [PRICE_W-1:0] walk_px = '0;
  bit walk_up = 1'b0;

  function automatic int unsigned win_eff(logic [WIN_W-1:0] w);
    if (w == 0) return 1;
    if (w > WIN_MAX) return WIN_MAX;
    return w;
  endfunction

  function automatic void forget_history();
    hist_fill = 0;
    short_total = 0;
    long_total = 0;
    prior_rel = REL_EQUAL;
    prior_rel_ok = 1'b0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < WIN_MAX; i++) px_hist[i] = '0;
    hist_head = 0;
    forget_history();
    holding = 1'b0;
    held_qty = '0;
    long_len = LONG_RST;
    short_len = SHORT_RST;
    buy_frac = FRAC_RST;
  endfunction

  function automatic void take_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_LONG: begin
        long_len = val[WIN_W-1:0];
        forget_history();
      end
      CFG_SHORT: begin
        short_len = val[WIN_W-1:0];
        forget_history();
      end
      CFG_FRAC: buy_frac = val[FRAC_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic trade_t predict_trade(tick_t t);
    int unsigned lw, sw;
    longint unsigned lhs, rhs, num, den, qty, bal, frac;
    rel_t now_rel;
    trade_t r;
    lw = win_eff(long_len);
    sw = win_eff(short_len);
    frac = (buy_frac > FRAC_ONE) ? FRAC_ONE : buy_frac;
    r = '0;
    if (hist_fill >= sw) short_total -= px_hist[(hist_head + WIN_MAX - sw) % WIN_MAX];
    if (hist_fill >= lw) long_total -= px_hist[(hist_head + WIN_MAX - lw) % WIN_MAX];
    short_total += t.close_price;
    long_total += t.close_price;
    px_hist[hist_head] = t.close_price;
    hist_head = (hist_head + 1) % WIN_MAX;
    if (hist_fill < WIN_MAX) hist_fill++;
    if (hist_fill >= lw) begin
      // averages compared by cross-multiplying; short counts as zero until full
      lhs = (hist_fill >= sw) ? short_total * lw : 0;
      rhs = long_total * sw;
      if (lhs > rhs) now_rel = REL_ABOVE;
      else if (lhs < rhs) now_rel = REL_BELOW;
      else now_rel = REL_EQUAL;
      if (prior_rel_ok) begin
        if (prior_rel != REL_ABOVE && now_rel == REL_ABOVE && !holding) begin
          if (t.close_price == 0) begin
            r.zero_price_skip = 1'b1;
          end else begin
            bal = t.available_balance;
            num = bal * frac;
            den = {16'd0, t.close_price, 16'd0};
            qty = num / den;
            if (qty != 0) begin
              r.action = ACT_BUY;
              r.trade_shares = qty[BAL_W-1:0];
              r.trade_price = t.close_price;
              held_qty = qty[BAL_W-1:0];
              holding = 1'b1;
            end
          end
        end else if (prior_rel != REL_BELOW && now_rel == REL_BELOW && holding &&
                     held_qty != 0) begin
          r.action = ACT_SELL;
          r.trade_shares = held_qty;
          r.trade_price = t.close_price;
          held_qty = '0;
          holding = 1'b0;
        end
      end
      prior_rel = now_rel;
      prior_rel_ok = 1'b1;
    end
    r.position_held = holding;
    return r;
  endfunction

  task automatic flag_err(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_trade(trade_t got);
    trade_t want;
    if (due_trades.size() == 0) begin
      flag_err($sformatf("trade with nothing pending, action %0d", got.action));
    end else begin
      want = due_trades.pop_front();
      if (got.action !== want.action)
        flag_err($sformatf("action %0d, want %0d", got.action, want.action));
      if (got.trade_shares !== want.trade_shares)
        flag_err($sformatf("shares %0d, want %0d", got.trade_shares, want.trade_shares));
      if (got.trade_price !== want.trade_price)
        flag_err($sformatf("price %0d, want %0d", got.trade_price, want.trade_price));
      if (got.position_held !== want.position_held)
        flag_err($sformatf("position %b, want %b", got.position_held, want.position_held));
      if (got.zero_price_skip !== want.zero_price_skip)
        flag_err($sformatf("zero skip %b, want %b", got.zero_price_skip,
                           want.zero_price_skip));
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 12) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  // monitor: sample at the rising edge, predict on tick transfer, check on trade transfer
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      tick_took = !rst && tick_valid && tick_ready;
      if (!rst) begin
        if (cfg_valid && cfg_ready) take_reg(cfg_index, cfg_data);
        if (tick_took) due_trades = {due_trades, predict_trade(tick)};
        if (trade_valid && trade_ready) check_trade(trade);
      end
    end
  end

  // tick driver
  always @(negedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || tick_took) begin
      if (gap_left > 0) begin
        gap_left--;
        tick_valid <= 1'b0;
      end else if (wait_drain && due_trades.size() != 0) begin
        tick_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        next_tick = tick_backlog.pop_front();
        tick <= next_tick;
        tick_valid <= 1'b1;
        wait_drain = ($urandom_range(0, 39) == 0);
        gap_left = (jitter_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // trade sink stalls
  always @(negedge clk) begin
    if (!jitter_on) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      trade_ready <= 1'b0;
      stall_left--;
    end else begin
      trade_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_tick(logic [PRICE_W-1:0] px, logic [BAL_W-1:0] bal);
    tick_t t;
    t.close_price = px;
    t.available_balance = bal;
    tick_backlog = {tick_backlog, t};
  endfunction

  task automatic settle();
    while (tick_backlog.size() != 0 || tick_valid || due_trades.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_phase(int unsigned n, price_shape_t shape, int unsigned flip);
    logic [PRICE_W-1:0] px;
    logic [BAL_W-1:0] bal;
    int unsigned step, i;
    if (shape == WALK_HIGH) walk_px = 32'hFFFF_0000 - $urandom_range(0, 32'h0010_0000);
    else walk_px = $urandom_range(1000, 1_000_000);
    for (i = 0; i < n; i++) begin
      if (i % flip == 0) walk_up = !walk_up;
      step = (shape == WALK_HIGH) ? $urandom_range(0, 40000) : $urandom_range(0, 80);
      if (walk_up) walk_px = (walk_px > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : walk_px + step;
      else walk_px = (walk_px < step) ? '0 : walk_px - step;
      case (shape)
        WALK_FLAT: px = $urandom_range(0, 3);
        WALK_NOISE: px = $urandom();
        default: px = walk_px;
      endcase
      if ($urandom_range(0, 59) == 0) px = '0;
      case ($urandom_range(0, 9))
        0: bal = $urandom_range(0, 500);
        1: bal = BAL_ALL;
        default: bal = {16'($urandom()), 32'($urandom())};
      endcase
      add_tick(px, bal);
    end
  endtask

  initial begin
    int unsigned done, n, lw_now, pick;
    price_shape_t shape;
    logic [WIN_W-1:0] lw_val, sw_val;
    logic [FRAC_W-1:0] frac_val;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // spare index ignored, fraction above one clamps, short window longer than long:
    // the late short average jumps above with a zero price, so the buy is skipped
    write_reg(CFG_SPARE, 17'h1FFFF);
    write_reg(CFG_FRAC, 17'h1FFFF);
    write_reg(CFG_LONG, {8'hA5, 9'd2});
    write_reg(CFG_SHORT, {8'h5A, 9'd4});
    add_tick(32'd100, BAL_ALL);
    add_tick(32'd100, BAL_ALL);
    add_tick(32'd0, BAL_ALL);
    add_tick(32'd0, BAL_ALL);
    settle();

    // short = last price: buy, sell, zero-share cross, extreme prices and balances
    jitter_on = 1'b1;
    write_reg(CFG_SHORT, {8'h5A, 9'd1});
    add_tick(32'd10, BAL_ALL);
    add_tick(32'd5, BAL_ALL);
    add_tick(32'd20, BAL_ALL);
    add_tick(32'd10, '0);
    add_tick(32'd20, '0);
    add_tick(32'd10, '0);
    add_tick(32'd30, 48'd1000);
    add_tick(32'hFFFF_FFFF, '0);
    add_tick(32'd5, '0);
    add_tick(32'hFFFF_FFFF, BAL_ALL);
    settle();
    write_reg(CFG_FRAC, 17'd0);
    add_tick(32'd3, BAL_ALL);
    add_tick(32'd9, BAL_ALL);
    add_tick(32'd1, BAL_ALL);
    settle();
    // zero windows count as one: averages always equal
    write_reg(CFG_LONG, 17'd0);
    write_reg(CFG_SHORT, 17'd0);
    add_tick(32'd0, BAL_ALL);
    add_tick(32'd7, BAL_ALL);
    add_tick(32'd0, '0);
    settle();

    // widest window, out-of-range value clamps to the maximum
    write_reg(CFG_FRAC, FRAC_ONE);
    write_reg(CFG_LONG, 17'd511);
    write_reg(CFG_SHORT, 17'd64);
    queue_phase(300, WALK_TREND, 90);
    settle();
    done = 300;

    while (done < 850) begin
      jitter_on = ($urandom_range(0, 3) != 0);
      // some phases keep the history so the ring wraps and the count saturates
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 11);
        if (pick == 0) lw_val = 9'd0;
        else if (pick == 1) lw_val = 9'd1;
        else if (pick == 2) lw_val = 9'd256;
        else lw_val = $urandom_range(2, 24);
        lw_now = win_eff(lw_val);
        pick = $urandom_range(0, 7);
        if (pick == 0) sw_val = 9'd0;
        else if (pick == 1) sw_val = $urandom_range(lw_now + 1, lw_now + 20);
        else if (pick == 2) sw_val = 9'd511;
        else sw_val = $urandom_range(1, lw_now);
        write_reg(CFG_LONG, {8'($urandom()), lw_val});
        write_reg(CFG_SHORT, {8'($urandom()), sw_val});
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) frac_val = '0;
      else if (pick == 1) frac_val = FRAC_ONE;
      else if (pick == 2) frac_val = $urandom_range(65537, 131071);
      else frac_val = $urandom_range(1000, 65536);
      write_reg(CFG_FRAC, frac_val);
      lw_now = win_eff(long_len);
      pick = $urandom_range(0, 19);
      if (pick < 2) shape = WALK_FLAT;
      else if (pick < 4) shape = WALK_HIGH;
      else if (pick < 7) shape = WALK_NOISE;
      else shape = WALK_TREND;
      n = (lw_now > 24) ? $urandom_range(20, 40) : $urandom_range(30, 70) + lw_now;
      queue_phase(n, shape, $urandom_range(lw_now / 2 + 1, 2 * lw_now + 4));
      settle();
      done += n;
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (err_count == 0 && due_trades.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
